// ===== rtl/core/mma_pkg.sv =====
// shared types and constants for the montgomery modular alu
`default_nettype none
package mma_pkg;
   typedef enum logic [1:0] {
      CMD_MUL   = 2'd0,
      CMD_POW   = 2'd1,
      CMD_INV   = 2'd2,
      CMD_MULSUB = 2'd3
   } cmd_type;

   localparam int OPERAND_BITS = 63;
   localparam int RESULT_BITS  = 64;
   localparam int EXP_BITS     = 64;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODULUS     = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEG_INVERSE = 1'd1;

   typedef struct packed {
      logic [1:0]              command;
      logic [OPERAND_BITS-1:0] operand_a;
      logic [OPERAND_BITS-1:0] operand_b;
      logic [OPERAND_BITS-1:0] operand_c;
      logic [OPERAND_BITS-1:0] operand_d;
      logic [EXP_BITS-1:0]     exponent;
   } req_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] result;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/core/mma_if.sv =====
// valid/ready channel interface carrying one transaction payload
`default_nettype none
interface mma_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/montgomery_modular_alu_top.sv =====
// montgomery modular alu top level with shared multiplier and sequencer
`default_nettype none
// Montgomery arithmetic over an odd modulus p < 2^63 with R = 2^64. One transaction
// on req gives one result on rsp. All work runs on a single 32x32 multiplier; a 128-bit
// product is built from four 32x32 partial products taken one per cycle, followed by
// a hand-off state. A Montgomery multiplication is three products (a*b, t*n', m*p)
// plus a load and a reduction state. Power does one multiplication per set exponent
// bit and one squaring per bit position up to the top set bit, and none for a zero
// exponent. Inverse runs the same loop, with exponent p-3. The block is not ready
// while the sequencer works. A finished result waits in the output register, and the
// next transaction may be taken meanwhile.
module montgomery_modular_alu_top #(
   parameter int WORD_BITS = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   mma_if.sink       req,
   mma_if.source     rsp,
   input  wire logic                                 csr_write_enable,
   input  wire logic [mma_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [mma_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import mma_pkg::*;

   localparam int WB = WORD_BITS;
   localparam logic [WB-1:0] WMASK = {WB{1'b1}};

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_MUL, S_MUL_DONE, S_RED_M, S_RED_MP, S_RED_FIN,
      S_SUB_SECOND, S_NEXT, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_XY, PH_TN, PH_MP
   } phase_type;

   logic [62:0]  modulus_ff;
   logic [63:0]  neg_inverse_ff;

   state_type    state_ff;
   phase_type    phase_ff;
   logic [1:0]   part_ff;
   logic [1:0]   cmd_ff;
   logic [63:0]  mx_ff, my_ff;
   logic [127:0] prod_ff;
   logic [127:0] t_ff;
   logic [63:0]  acc_ff, base_ff, exp_ff;
   logic [62:0]  opc_ff, opd_ff;
   logic         pass_ff;   // power: 0 = acc*base, 1 = base*base
   logic         second_ff; // mulsub: second product in progress
   logic [63:0]  res_ff;
   logic         rsp_valid_ff;

   // one 32x32 partial product per cycle
   logic [31:0] pp_x, pp_y;
   logic [63:0] pp;
   logic [127:0] pp_shift;
   always_comb begin
      pp_x = part_ff[0] ? mx_ff[63:32] : mx_ff[31:0];
      pp_y = part_ff[1] ? my_ff[63:32] : my_ff[31:0];
      pp = pp_x * pp_y;
      pp_shift = {64'd0, pp} << {{1'b0, part_ff[0]} + {1'b0, part_ff[1]}, 5'd0};
   end

   // reduction result
   logic [127:0] pr_r;
   logic [127:0] shmod;
   logic [63:0]  q;
   logic [63:0]  red;
   always_comb begin
      shmod = {65'd0, modulus_ff} << WB;
      pr_r  = t_ff + prod_ff;
      q     = 64'(pr_r >> WB);
      red   = (q >= {1'b0, modulus_ff}) ? q - {1'b0, modulus_ff} : q;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload.result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= 63'd3;
         neg_inverse_ff <= 64'd0;
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         part_ff        <= 2'd0;
         phase_ff       <= PH_XY;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_MODULUS:     modulus_ff <= csr_write_data[62:0];
               CSR_NEG_INVERSE: neg_inverse_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  cmd_ff    <= req.payload.command;
                  acc_ff    <= (req.payload.command == CMD_INV)
                               ? {1'b0, req.payload.operand_b}
                               : {1'b0, req.payload.operand_a};
                  base_ff   <= {1'b0, req.payload.operand_b};
                  opc_ff    <= req.payload.operand_c;
                  opd_ff    <= req.payload.operand_d;
                  exp_ff    <= (req.payload.command == CMD_INV)
                               ? {1'b0, modulus_ff} - 64'd3 : req.payload.exponent;
                  second_ff <= 1'b0;
                  pass_ff   <= 1'b0;
                  state_ff  <= S_LOAD;
               end
            end
            S_LOAD: begin
               // choose the next montgomery multiplication, or finish on a zero exponent
               phase_ff <= PH_XY;
               part_ff  <= 2'd0;
               prod_ff  <= '0;
               t_ff     <= '0;
               if (cmd_ff == CMD_MUL || cmd_ff == CMD_MULSUB) begin
                  mx_ff <= acc_ff; my_ff <= base_ff; state_ff <= S_MUL;
               end else if (exp_ff == 64'd0) begin
                  state_ff <= S_OUT;
               end else if (!pass_ff && exp_ff[0]) begin
                  mx_ff <= acc_ff; my_ff <= base_ff; state_ff <= S_MUL;
               end else begin
                  pass_ff <= 1'b1;
                  mx_ff <= base_ff; my_ff <= base_ff; state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff <= prod_ff + pp_shift;
               part_ff <= part_ff + 2'd1;
               if (part_ff == 2'd3) state_ff <= S_MUL_DONE;
            end
            S_MUL_DONE: begin
               part_ff <= 2'd0;
               unique case (phase_ff)
                  PH_XY: begin
                     if (cmd_ff == CMD_MULSUB && !second_ff) begin
                        t_ff <= prod_ff + shmod;
                        prod_ff <= '0;
                        second_ff <= 1'b1;
                        mx_ff <= {1'b0, opc_ff}; my_ff <= {1'b0, opd_ff};
                        state_ff <= S_MUL;
                     end else begin
                        if (cmd_ff == CMD_MULSUB) t_ff <= t_ff - prod_ff;
                        else t_ff <= prod_ff;
                        mx_ff <= (cmd_ff == CMD_MULSUB) ? 64'(t_ff - prod_ff) & WMASK
                                                        : prod_ff[63:0] & WMASK;
                        my_ff <= neg_inverse_ff;
                        prod_ff <= '0;
                        phase_ff <= PH_TN;
                        state_ff <= S_MUL;
                     end
                  end
                  PH_TN: begin
                     mx_ff <= prod_ff[63:0] & WMASK;
                     my_ff <= {1'b0, modulus_ff};
                     prod_ff <= '0;
                     phase_ff <= PH_MP;
                     state_ff <= S_MUL;
                  end
                  default: state_ff <= S_RED_FIN;
               endcase
            end
            S_RED_FIN: begin
               if (cmd_ff == CMD_MUL || cmd_ff == CMD_MULSUB) begin
                  acc_ff <= red; state_ff <= S_OUT;
               end else if (!pass_ff) begin
                  acc_ff <= red; pass_ff <= 1'b1; state_ff <= S_LOAD;
               end else begin
                  base_ff <= red; pass_ff <= 1'b0;
                  exp_ff <= exp_ff >> 1; state_ff <= S_LOAD;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  res_ff <= acc_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_valid_ff && $stable(res_ff)))
      else $error("result changed while stalled");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == S_LOAD)) else $error("no start");
`endif
endmodule
`default_nettype wire
